FILE: src/msd_pkg.sv
// Shared types, constants and the segment decode for the multiplexed
// seven-segment display driver. No dependencies.
package msd_pkg;

    // Number of display digits and the derived widths.
    localparam int DIGITS = 4;
    localparam int POS_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int NUM_W = 16;
    localparam int DP_W = 2;
    localparam int ENABLE_W = 4;
    localparam int SEG_W = 8;
    localparam int BIT_CNT_W = $clog2(SEG_W + 1);

    // All digit enables off (active low), masked to the enable field.
    localparam logic [ENABLE_W-1:0] ALL_OFF = ENABLE_W'((1 << DIGITS) - 1);

    // Divide by ten as a multiply by a scaled reciprocal; exact for 16-bit values.
    localparam int RECIP_W = 17;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 17'd52429;
    localparam int RECIP_SHIFT = 19;

    // Request function codes.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_REFRESH = 1'b1;

    typedef struct packed {
        logic              func;
        logic [NUM_W-1:0]  number;
        logic [DP_W-1:0]   decimal_point_pos;
    } in_item_t;

    typedef struct packed {
        logic                serial_bit;
        logic                shift_pulse;
        logic                latch_pulse;
        logic [ENABLE_W-1:0] digit_enable_n;
        logic                last;
    } out_item_t;

    // Classified command as it sits in the queue.
    typedef struct packed {
        logic              refresh;
        logic [NUM_W-1:0]  number;
        logic [DIGITS-1:0] dp_mask;
    } cmd_t;

    // Segment pattern for one decimal digit, bit 0 = segment a.
    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
        logic [SEG_W-1:0] pattern;
        case (digit)
            4'd0:    pattern = 8'h3F;
            4'd1:    pattern = 8'h06;
            4'd2:    pattern = 8'h5B;
            4'd3:    pattern = 8'h4F;
            4'd4:    pattern = 8'h66;
            4'd5:    pattern = 8'h6D;
            4'd6:    pattern = 8'h7D;
            4'd7:    pattern = 8'h07;
            4'd8:    pattern = 8'h7F;
            4'd9:    pattern = 8'h6F;
            default: pattern = 8'h00;
        endcase
        return pattern;
    endfunction

endpackage

FILE: src/mux_seven_segment_driver_unit.sv
// Top level of the multiplexed seven-segment display driver.
// Depends on msd_pkg, msd_front, msd_queue and msd_back.
//
//   Channel  Signals                          Payload                Direction
//   item     item_valid, item_stall, item     msd_pkg::in_item_t     into block
//   result   result_valid, result_stall,      msd_pkg::out_item_t    out of block
//            result
//
// A refresh request yields nine results, one per cycle while result_stall is low:
// eight shift results and a closing latch result. Back-to-back refreshes follow
// without a gap, since the next one starts in the latch cycle of the previous.
// A load request occupies the back end while it converts one digit per cycle
// with the shared divide-by-ten step, and yields no results.
// Reset clears the stored segment bytes (blank display) and the digit position.
// A two-entry queue decouples the sides: item_stall rises only when it is full.
module mux_seven_segment_driver_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  msd_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output msd_pkg::out_item_t result
);

    msd_pkg::cmd_t front_cmd;
    msd_pkg::cmd_t head_cmd;
    logic          queue_full;
    logic          head_valid;
    logic          head_pop;

    // Classify the request: refresh or load, with its decimal point mask.
    msd_front u_front (
        .item (item),
        .cmd  (front_cmd)
    );

    // The queue accepts whenever it has room, independent of the result side.
    msd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (item_valid),
        .push_cmd   (front_cmd),
        .full       (queue_full),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    assign item_stall = queue_full;

    // The back end holds the segment bytes and the output register.
    msd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (head_valid),
        .cmd          (head_cmd),
        .cmd_pop      (head_pop),
        .result_valid (result_valid),
        .result       (result),
        .result_stall (result_stall)
    );

endmodule

FILE: src/msd_front.sv
// Front end: classifies an incoming request into a queue command.
// Depends on msd_pkg.
module msd_front (
    input  msd_pkg::in_item_t item,
    output msd_pkg::cmd_t     cmd
);

    logic [msd_pkg::DIGITS-1:0] dp_mask;

    // Only digits one and two carry a decimal point, and only if they exist.
    always_comb
    begin
        for (int k = 0; k < msd_pkg::DIGITS; k++)
        begin
            dp_mask[k] = (int'(item.decimal_point_pos) == k) && (k == 1 || k == 2);
        end
    end

    assign cmd.refresh = (item.func == msd_pkg::FUNC_REFRESH);
    assign cmd.number  = item.number;
    assign cmd.dp_mask = dp_mask;

endmodule

FILE: src/msd_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on msd_pkg.
module msd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  msd_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output msd_pkg::cmd_t head_cmd
);

    msd_pkg::cmd_t mem_reg [2];
    msd_pkg::cmd_t mem_next [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        mem_next    = mem_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            mem_next[wr_ptr_reg] = push_cmd;
            wr_ptr_next = !wr_ptr_reg;
        end
        if (do_pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        mem_reg <= mem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: src/msd_back.sv
// Back end: converts loads into stored segment bytes one digit per cycle and
// plays refresh ticks out as shift and latch results. Depends on msd_pkg.
module msd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  msd_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    output logic               result_valid,
    output msd_pkg::out_item_t result,
    input  logic               result_stall
);

    typedef enum logic [1:0] {ST_IDLE, ST_CONVERT, ST_SHIFT} state_t;

    state_t                          state_reg, state_next;
    logic [msd_pkg::NUM_W-1:0]       work_reg, work_next;
    logic [msd_pkg::DIGITS-1:0]      dp_mask_reg, dp_mask_next;
    logic [msd_pkg::POS_W-1:0]       cnt_reg, cnt_next;
    logic [msd_pkg::SEG_W-1:0]       seg_reg [msd_pkg::DIGITS];
    logic [msd_pkg::SEG_W-1:0]       seg_next [msd_pkg::DIGITS];
    logic [msd_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [msd_pkg::SEG_W-1:0]       shift_reg, shift_next;
    logic [msd_pkg::BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic                            out_valid_reg, out_valid_next;
    msd_pkg::out_item_t              out_reg, out_next;

    logic                                        out_free;
    logic [msd_pkg::NUM_W+msd_pkg::RECIP_W-1:0]  prod;
    logic [msd_pkg::NUM_W-1:0]                   quot;
    logic [msd_pkg::NUM_W-1:0]                   quot_ten;
    logic [msd_pkg::NUM_W-1:0]                   diff;
    logic [msd_pkg::POS_W-1:0]                   pos_inc;
    logic                                        shift_done;
    logic                                        can_start;

    assign out_free = !out_valid_reg || !result_stall;

    // One decimal digit per cycle: quotient by reciprocal, remainder by subtract.
    assign prod     = work_reg * msd_pkg::RECIP_TEN;
    assign quot     = msd_pkg::NUM_W'(prod >> msd_pkg::RECIP_SHIFT);
    assign quot_ten = msd_pkg::NUM_W'(quot * 16'd10);
    assign diff     = work_reg - quot_ten;

    assign pos_inc = (int'(pos_reg) == msd_pkg::DIGITS - 1) ? '0 : pos_reg + 1'b1;

    assign shift_done = (state_reg == ST_SHIFT) && out_free &&
                        (int'(bit_cnt_reg) == msd_pkg::SEG_W);
    assign can_start  = (state_reg == ST_IDLE) || shift_done;
    assign cmd_pop    = cmd_valid && can_start;

    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        dp_mask_next   = dp_mask_reg;
        cnt_next       = cnt_reg;
        seg_next       = seg_reg;
        pos_next       = pos_reg;
        shift_next     = shift_reg;
        bit_cnt_next   = bit_cnt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_CONVERT:
            begin
                seg_next[cnt_reg] = msd_pkg::seg_of(diff[3:0]) |
                                    {dp_mask_reg[cnt_reg], 7'b0};
                work_next = quot;
                if (cnt_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_SHIFT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (int'(bit_cnt_reg) == msd_pkg::SEG_W)
                    begin
                        // Data line keeps the last bit while the latch fires.
                        out_next.serial_bit     = out_reg.serial_bit;
                        out_next.shift_pulse    = 1'b0;
                        out_next.latch_pulse    = 1'b1;
                        out_next.digit_enable_n = msd_pkg::ALL_OFF &
                            ~(msd_pkg::ENABLE_W'(1) << pos_reg);
                        out_next.last           = 1'b1;
                        pos_next   = pos_inc;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        out_next.serial_bit     = shift_reg[msd_pkg::SEG_W-1];
                        out_next.shift_pulse    = 1'b1;
                        out_next.latch_pulse    = 1'b0;
                        out_next.digit_enable_n = msd_pkg::ALL_OFF;
                        out_next.last           = 1'b0;
                        shift_next   = {shift_reg[msd_pkg::SEG_W-2:0], 1'b0};
                        bit_cnt_next = bit_cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A new command may start in the cycle the previous refresh latches.
        if (cmd_pop)
        begin
            if (cmd.refresh)
            begin
                shift_next   = seg_reg[shift_done ? pos_inc : pos_reg];
                bit_cnt_next = '0;
                state_next   = ST_SHIFT;
            end
            else
            begin
                work_next    = cmd.number;
                dp_mask_next = cmd.dp_mask;
                cnt_next     = msd_pkg::POS_W'(msd_pkg::DIGITS - 1);
                state_next   = ST_CONVERT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seg_reg       <= '{default: '0};
            pos_reg       <= '0;
            cnt_reg       <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seg_reg       <= seg_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        dp_mask_reg <= dp_mask_next;
        shift_reg   <= shift_next;
        out_reg     <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

FILE: sim/tb_mux_seven_segment_driver_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for mux_seven_segment_driver_unit: load and refresh requests
// go in, and every scan result is checked against an untimed model of the display.
// Depends on msd_pkg and the block's RTL only.
module tb_mux_seven_segment_driver_unit;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 6;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 30;
    localparam int RANDOM_REQUESTS = 110;
    localparam int REPORT_LIMIT    = 10;

    // Idle and stall chances in percent for the three traffic phases:
    // a slow receiver first, then a slow sender, then full speed on both sides.
    localparam int SEND_IDLE_PCT [3] = '{9, 78, 0};
    localparam int RECV_IDLE_PCT [3] = '{78, 9, 0};

    // Segment patterns for the decimal digits, bit 0 is segment a.
    localparam logic [7:0] GLYPH [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };
    localparam int unsigned PLACE_VALUE [4] = '{1000, 100, 10, 1};

    // A request waiting to be sent, with the traffic pattern of its phase.
    typedef struct {
        msd_pkg::in_item_t req;
        bit                drain_first;
        int                send_idle_pct;
        int                recv_idle_pct;
    } backlog_entry_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_stall;
    msd_pkg::in_item_t  item = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    msd_pkg::out_item_t result;

    // Model state: the four stored segment bytes and the digit being scanned.
    logic [7:0]         display_bytes [msd_pkg::DIGITS];
    int                 scan_position;

    backlog_entry_t     request_backlog [$];
    msd_pkg::out_item_t scan_results_due [$];

    int error_count     = 0;
    int loads_sent      = 0;
    int refreshes_sent  = 0;
    int results_checked = 0;
    int cycle_count     = 0;
    int fill_phase      = 0;
    bit drain_next      = 1'b0;
    int recv_stall_pct  = 0;

    mux_seven_segment_driver_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic void flag_error(input string what);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("[%0t] ERROR: %s", $time, what);
    endfunction

    // Applies one accepted request to the display model. A load rewrites the stored
    // bytes and yields nothing. A refresh yields eight shift results carrying the
    // current byte from bit 7 down, all digits dark, and then one latch result that
    // lights only the current digit and leaves bit 0 on the data line.
    function automatic void apply_display_request(input msd_pkg::in_item_t r);
        logic [7:0]         pattern;
        msd_pkg::out_item_t res;
        int                 k;
        if (r.func == msd_pkg::FUNC_LOAD)
        begin
            for (k = 0; k < msd_pkg::DIGITS; k++)
                display_bytes[k] = GLYPH[(int'(r.number) / PLACE_VALUE[k]) % 10];
            // Only the second and third digits carry a usable point.
            if (r.decimal_point_pos == 2'd1 || r.decimal_point_pos == 2'd2)
                display_bytes[r.decimal_point_pos][7] = 1'b1;
            loads_sent++;
        end
        else
        begin
            pattern = display_bytes[scan_position];
            for (k = 0; k < 8; k++)
            begin
                res.serial_bit     = pattern[7 - k];
                res.shift_pulse    = 1'b1;
                res.latch_pulse    = 1'b0;
                res.digit_enable_n = msd_pkg::ALL_OFF;
                res.last           = 1'b0;
                scan_results_due.push_back(res);
            end
            res.serial_bit     = pattern[0];
            res.shift_pulse    = 1'b0;
            res.latch_pulse    = 1'b1;
            res.digit_enable_n = msd_pkg::ALL_OFF & ~(msd_pkg::ENABLE_W'(1) << scan_position);
            res.last           = 1'b1;
            scan_results_due.push_back(res);
            scan_position = (scan_position + 1) % msd_pkg::DIGITS;
            refreshes_sent++;
        end
    endfunction

    function automatic void queue_request(input logic func, input logic [15:0] number,
                                          input logic [1:0] dp);
        backlog_entry_t e;
        e.req.func              = func;
        e.req.number            = number;
        e.req.decimal_point_pos = dp;
        // Now and then the sender waits for the scan to drain completely.
        e.drain_first   = drain_next || ($urandom_range(0, 99) < 3);
        e.send_idle_pct = SEND_IDLE_PCT[fill_phase];
        e.recv_idle_pct = RECV_IDLE_PCT[fill_phase];
        drain_next      = 1'b0;
        request_backlog.push_back(e);
    endfunction

    function automatic logic [15:0] pick_number();
        logic [15:0] corner [5];
        corner = '{16'd0, 16'd9999, 16'd10000, 16'd65535, 16'd1000};
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 9999));
            1:       return corner[$urandom_range(0, 4)];
            2:       return 16'($urandom_range(0, 99));
            default: return 16'($urandom);
        endcase
    endfunction

    // Request driver. A request is accepted on an edge where valid is high and
    // stall is low; the model is updated right then. A stalled request is held
    // unchanged, and the next one is offered only when the sender is not idling.
    always @(posedge clk)
    begin
        backlog_entry_t next_entry;
        bit             offer;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                apply_display_request(item);
            if (!(item_valid && item_stall))
            begin
                offer = 1'b0;
                if (request_backlog.size() > 0)
                    offer = (!request_backlog[0].drain_first || scan_results_due.size() == 0)
                            && ($urandom_range(0, 99) >= request_backlog[0].send_idle_pct);
                if (offer)
                begin
                    next_entry     = request_backlog.pop_front();
                    recv_stall_pct = next_entry.recv_idle_pct;
                    item_valid    <= 1'b1;
                    item          <= next_entry.req;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Each accepted result is matched against the oldest scan
    // result still due, and the receiver stalls at random for the next edge.
    always @(posedge clk)
    begin
        msd_pkg::out_item_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (scan_results_due.size() == 0)
                begin
                    flag_error($sformatf({"result with none due: ",
                               "bit=%b shift=%b latch=%b en_n=%b last=%b"},
                               result.serial_bit, result.shift_pulse, result.latch_pulse,
                               result.digit_enable_n, result.last));
                end
                else
                begin
                    want = scan_results_due.pop_front();
                    results_checked++;
                    if (result.serial_bit !== want.serial_bit
                        || result.shift_pulse !== want.shift_pulse
                        || result.latch_pulse !== want.latch_pulse
                        || result.digit_enable_n !== want.digit_enable_n
                        || result.last !== want.last)
                        flag_error($sformatf({"result %0d: expected bit=%b shift=%b ",
                                   "latch=%b en_n=%b last=%b, got bit=%b shift=%b ",
                                   "latch=%b en_n=%b last=%b"},
                                   results_checked, want.serial_bit, want.shift_pulse,
                                   want.latch_pulse, want.digit_enable_n, want.last,
                                   result.serial_bit, result.shift_pulse, result.latch_pulse,
                                   result.digit_enable_n, result.last));
                end
            end
            result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // A hung handshake ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("mux_seven_segment_driver_unit verification failed");
        $finish;
    end

    initial
    begin
        int i;
        for (i = 0; i < msd_pkg::DIGITS; i++)
            display_bytes[i] = 8'h00;
        scan_position = 0;

        // Directed part. Refreshes before any load scan the blank display. Then
        // every digit value, points on the second and third digits, the ignored
        // point codes, values above 9999 and the position wrap are covered.
        queue_request(msd_pkg::FUNC_REFRESH, 16'hFFFF, 2'd3);
        queue_request(msd_pkg::FUNC_REFRESH, 16'h0000, 2'd0);
        queue_request(msd_pkg::FUNC_LOAD, 16'd9999, 2'd1);
        queue_request(msd_pkg::FUNC_REFRESH, 16'hA5A5, 2'd1);
        queue_request(msd_pkg::FUNC_REFRESH, 16'h5A5A, 2'd2);
        queue_request(msd_pkg::FUNC_REFRESH, 16'h0000, 2'd0);
        queue_request(msd_pkg::FUNC_LOAD, 16'd65535, 2'd2);
        queue_request(msd_pkg::FUNC_REFRESH, 16'h0000, 2'd0);
        queue_request(msd_pkg::FUNC_REFRESH, 16'h0000, 2'd0);
        queue_request(msd_pkg::FUNC_LOAD, 16'd10000, 2'd3);
        queue_request(msd_pkg::FUNC_REFRESH, 16'h1234, 2'd3);
        queue_request(msd_pkg::FUNC_LOAD, 16'd12345, 2'd0);
        queue_request(msd_pkg::FUNC_REFRESH, 16'h0000, 2'd0);
        queue_request(msd_pkg::FUNC_LOAD, 16'd8, 2'd1);
        queue_request(msd_pkg::FUNC_LOAD, 16'd1234, 2'd2);
        queue_request(msd_pkg::FUNC_REFRESH, 16'h0000, 2'd0);
        queue_request(msd_pkg::FUNC_REFRESH, 16'h0000, 2'd0);
        queue_request(msd_pkg::FUNC_REFRESH, 16'h0000, 2'd0);
        queue_request(msd_pkg::FUNC_LOAD, 16'd6780, 2'd1);
        queue_request(msd_pkg::FUNC_REFRESH, 16'h0000, 2'd0);

        // Random part, mostly refreshes so the scan keeps running, in three
        // traffic phases. Each new phase starts once all due scan results have drained.
        for (i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i == 40 || i == 85)
            begin
                fill_phase++;
                drain_next = 1'b1;
            end
            if ($urandom_range(0, 99) < 62)
                queue_request(msd_pkg::FUNC_REFRESH, 16'($urandom),
                              2'($urandom_range(0, 3)));
            else
                queue_request(msd_pkg::FUNC_LOAD, pick_number(), 2'($urandom_range(0, 3)));
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (!(request_backlog.size() == 0 && !item_valid && scan_results_due.size() == 0));
        // Let a trailing load finish and catch any stray results.
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d loads and %0d refreshes under three traffic mixes,", loads_sent,
                 refreshes_sent);
        $display("checked %0d scan results, %0d errors.", results_checked, error_count);
        if (error_count == 0)
            $display("mux_seven_segment_driver_unit verification clean");
        else
            $display("mux_seven_segment_driver_unit verification failed");
        $finish;
    end

endmodule
